// ===== sv/psot_pkg.sv =====
// ----------------------------------------------------------------------------
// psot_pkg
// Shared types and constants of the periodic sphere overlap test.
// ----------------------------------------------------------------------------
package psot_pkg;

	localparam int COORD_W  = 16;
	localparam int IDX_W    = 16;
	localparam int DIFF_W   = COORD_W + 3;
	localparam int MAG_W    = COORD_W + 2;
	localparam int SQ_W     = 2 * MAG_W;
	localparam int P_W      = 2 * COORD_W + 1;
	localparam int PH_W     = P_W - COORD_W;
	localparam int T_W      = 2 * P_W;
	localparam int SEP_W    = 18;
	localparam int REM_W    = SEP_W + 3;
	localparam int SQ_STEPS = 3;
	localparam int SQ_STAGES = SEP_W / SQ_STEPS;
	localparam int CNT_W    = 5;
	localparam int MAX_IMAGES = 27;
	localparam int CFG_IDX_W = 3;

	localparam logic [CFG_IDX_W-1:0] CFG_BOX_X = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BOX_Y = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_BOX_Z = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_DEPTH = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_SCALE = 3'd4;

	typedef struct packed {
		logic [COORD_W-1:0] box_x;
		logic [COORD_W-1:0] box_y;
		logic [COORD_W-1:0] box_z;
		logic               depth;
		logic [COORD_W-1:0] scale;
	} cfg_t;

	typedef struct packed {
		logic [COORD_W-1:0] x1;
		logic [COORD_W-1:0] y1;
		logic [COORD_W-1:0] z1;
		logic [COORD_W-1:0] d1;
		logic [COORD_W-1:0] x2;
		logic [COORD_W-1:0] y2;
		logic [COORD_W-1:0] z2;
		logic [COORD_W-1:0] d2;
	} pair_t;

	typedef struct packed {
		logic              lst;
		logic [IDX_W-1:0]  fi;
		logic [IDX_W-1:0]  si;
		logic signed [1:0] kx;
		logic signed [1:0] ky;
		logic signed [1:0] kz;
	} meta_t;

endpackage

// ===== sv/periodic_sphere_overlap_test_top.sv =====
// ----------------------------------------------------------------------------
// periodic_sphere_overlap_test_top
// Tests a sphere pair under each periodic image and reports overlaps.
// Path: nine pipeline stages from the image iterator, then the result bank.
// Throughput: one image per cycle while no full result bank stalls the
//   pipeline; the image iterator issues 27 images per pair at depth one, 1 at depth zero.
// Results of a pair leave after its last image; two result banks overlap
// collection of one pair with output of the previous one.
// Reset: async, active low; registers to defaults, all banks empty.
// ----------------------------------------------------------------------------
module periodic_sphere_overlap_test_top import psot_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_we,
	input  logic [CFG_IDX_W-1:0]    cfg_index,
	input  logic [COORD_W-1:0]      cfg_data,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic [IDX_W-1:0]        first_index,
	input  logic [IDX_W-1:0]        second_index,
	input  logic [COORD_W-1:0]      first_x,
	input  logic [COORD_W-1:0]      first_y,
	input  logic [COORD_W-1:0]      first_z,
	input  logic [COORD_W-1:0]      first_diameter,
	input  logic [COORD_W-1:0]      second_x,
	input  logic [COORD_W-1:0]      second_y,
	input  logic [COORD_W-1:0]      second_z,
	input  logic [COORD_W-1:0]      second_diameter,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic [IDX_W-1:0]        pair_first,
	output logic [IDX_W-1:0]        pair_second,
	output logic signed [1:0]       shift_x,
	output logic signed [1:0]       shift_y,
	output logic signed [1:0]       shift_z,
	output logic [SEP_W-1:0]        separation,
	output logic                    overlap,
	output logic [CNT_W-1:0]        image_count,
	output logic                    last
);

	typedef struct packed {
		logic signed [1:0] kx;
		logic signed [1:0] ky;
		logic signed [1:0] kz;
		logic [SEP_W-1:0]  sep;
	} ent_t;

	cfg_t              cfg_q;
	logic              busy_q;
	pair_t             pair_q;
	logic [IDX_W-1:0]  fi_q, si_q;
	logic signed [1:0] kx_q, ky_q, kz_q;
	logic signed [1:0] kstart, kend;
	logic              it_last, acc, adv;

	logic              pv;
	meta_t             pmeta;
	logic              phit;
	logic [SEP_W-1:0]  psep;

	logic              wb_q, rb_q;
	logic [CNT_W-1:0]  wcnt_q, ri_q;
	logic              full_q [2];
	logic [CNT_W-1:0]  cnt_q  [2];
	logic [IDX_W-1:0]  bfi_q  [2];
	logic [IDX_W-1:0]  bsi_q  [2];
	ent_t              ent0_q [MAX_IMAGES];
	ent_t              ent1_q [MAX_IMAGES];
	ent_t              rd;
	logic [CNT_W-1:0]  rcnt;
	logic              out_acc, wr;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.box_x <= 16'd25600;
			cfg_q.box_y <= 16'd25600;
			cfg_q.box_z <= 16'd25600;
			cfg_q.depth <= 1'b1;
			cfg_q.scale <= 16'd4096;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_BOX_X: cfg_q.box_x <= cfg_data;
				CFG_BOX_Y: cfg_q.box_y <= cfg_data;
				CFG_BOX_Z: cfg_q.box_z <= cfg_data;
				CFG_DEPTH: cfg_q.depth <= cfg_data[0];
				CFG_SCALE: cfg_q.scale <= cfg_data;
				default: ;
			endcase
		end
	end

	// image iterator
	assign kstart  = cfg_q.depth ? -2'sd1 : 2'sd0;
	assign kend    = cfg_q.depth ? 2'sd1 : 2'sd0;
	assign it_last = (kx_q == kend) && (ky_q == kend) && (kz_q == kend);
	assign adv     = !(pv && full_q[wb_q]);
	assign in_ready = adv && (!busy_q || it_last);
	assign acc     = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			kx_q   <= 2'sd0;
			ky_q   <= 2'sd0;
			kz_q   <= 2'sd0;
		end else if (acc) begin
			busy_q <= 1'b1;
			kx_q   <= kstart;
			ky_q   <= kstart;
			kz_q   <= kstart;
		end else if (adv && busy_q) begin
			if (it_last) begin
				busy_q <= 1'b0;
			end else if (kz_q != kend) begin
				kz_q <= kz_q + 2'sd1;
			end else begin
				kz_q <= kstart;
				if (ky_q != kend) begin
					ky_q <= ky_q + 2'sd1;
				end else begin
					ky_q <= kstart;
					kx_q <= kx_q + 2'sd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			fi_q   <= first_index;
			si_q   <= second_index;
			pair_q <= '{x1: first_x, y1: first_y, z1: first_z, d1: first_diameter,
			            x2: second_x, y2: second_y, z2: second_z, d2: second_diameter};
		end
	end

	psot_pipe u_pipe (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.cfg       (cfg_q),
		.in_valid  (busy_q),
		.in_meta   ('{lst: it_last, fi: fi_q, si: si_q, kx: kx_q, ky: ky_q, kz: kz_q}),
		.in_pair   (pair_q),
		.out_valid (pv),
		.out_meta  (pmeta),
		.out_hit   (phit),
		.out_sep   (psep)
	);

	// result banks
	assign wr      = pv && adv;
	assign out_acc = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wb_q      <= 1'b0;
			rb_q      <= 1'b0;
			wcnt_q    <= '0;
			ri_q      <= '0;
			full_q[0] <= 1'b0;
			full_q[1] <= 1'b0;
		end else begin
			if (wr) begin
				if (pmeta.lst) begin
					full_q[wb_q] <= 1'b1;
					wb_q         <= !wb_q;
					wcnt_q       <= '0;
				end else begin
					wcnt_q <= wcnt_q + CNT_W'(phit);
				end
			end
			if (out_acc) begin
				if (last) begin
					full_q[rb_q] <= 1'b0;
					rb_q         <= !rb_q;
					ri_q         <= '0;
				end else begin
					ri_q <= ri_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr) begin
			if (phit) begin
				if (wb_q) begin
					ent1_q[wcnt_q] <= '{kx: pmeta.kx, ky: pmeta.ky, kz: pmeta.kz, sep: psep};
				end else begin
					ent0_q[wcnt_q] <= '{kx: pmeta.kx, ky: pmeta.ky, kz: pmeta.kz, sep: psep};
				end
			end
			if (pmeta.lst) begin
				cnt_q[wb_q] <= wcnt_q + CNT_W'(phit);
				bfi_q[wb_q] <= pmeta.fi;
				bsi_q[wb_q] <= pmeta.si;
			end
		end
	end

	assign rd   = rb_q ? ent1_q[ri_q] : ent0_q[ri_q];
	assign rcnt = cnt_q[rb_q];

	assign out_valid   = full_q[rb_q];
	assign pair_first  = bfi_q[rb_q];
	assign pair_second = bsi_q[rb_q];
	assign overlap     = (rcnt != '0);
	assign image_count = rcnt;
	assign last        = (rcnt == '0) || (ri_q == rcnt - 1'b1);
	assign shift_x     = overlap ? rd.kx : 2'sd0;
	assign shift_y     = overlap ? rd.ky : 2'sd0;
	assign shift_z     = overlap ? rd.kz : 2'sd0;
	assign separation  = overlap ? rd.sep : '0;

endmodule

// ===== sv/psot_pipe.sv =====
// ----------------------------------------------------------------------------
// psot_pipe
// Image test pipeline: offsets, squares, contact compare and a staged
// integer square root of the squared distance.
// ----------------------------------------------------------------------------
module psot_pipe import psot_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               adv,
	input  cfg_t               cfg,
	input  logic               in_valid,
	input  meta_t              in_meta,
	input  pair_t              in_pair,
	output logic               out_valid,
	output meta_t              out_meta,
	output logic               out_hit,
	output logic [SEP_W-1:0]   out_sep
);

	typedef struct packed {
		logic [SQ_W-1:0]  rad;
		logic [REM_W-1:0] rem;
		logic [SEP_W-1:0] root;
	} sq_t;

	function automatic logic signed [DIFF_W-1:0] offs(logic signed [1:0] k,
			logic [COORD_W-1:0] box, logic [COORD_W-1:0] a, logic [COORD_W-1:0] b);
		logic signed [DIFF_W-1:0] base;
		logic signed [DIFF_W-1:0] bx;
		base = $signed({3'b000, a}) - $signed({3'b000, b});
		bx   = $signed({3'b000, box});
		unique case (k)
			2'sd1:   offs = base + bx;
			-2'sd1:  offs = base - bx;
			default: offs = base;
		endcase
	endfunction

	function automatic logic [MAG_W-1:0] mag(logic signed [DIFF_W-1:0] d);
		logic signed [DIFF_W-1:0] n;
		n = d[DIFF_W-1] ? -d : d;
		mag = n[MAG_W-1:0];
	endfunction

	function automatic sq_t sq_step(sq_t st);
		sq_t r;
		logic [REM_W-1:0] trial;
		r = st;
		for (int i = 0; i < SQ_STEPS; i++) begin
			r.rem = {r.rem[REM_W-3:0], r.rad[SQ_W-1 -: 2]};
			r.rad = {r.rad[SQ_W-3:0], 2'b00};
			trial = {1'b0, r.root, 2'b01};
			if (r.rem >= trial) begin
				r.rem  = r.rem - trial;
				r.root = {r.root[SEP_W-2:0], 1'b1};
			end else begin
				r.root = {r.root[SEP_W-2:0], 1'b0};
			end
		end
		return r;
	endfunction

	// stage 1: offsets and contact product
	logic                     v_s1;
	meta_t                    meta_s1;
	logic signed [DIFF_W-1:0] dx_s1, dy_s1, dz_s1;
	logic [P_W-1:0]           p_s1;
	// stage 2: squares
	logic                     v_s2;
	meta_t                    meta_s2;
	logic [SQ_W-1:0]          sqx_s2, sqy_s2, sqz_s2;
	logic [2*PH_W-1:0]        aa_s2;
	logic [PH_W+COORD_W-1:0]  ab_s2;
	logic [2*COORD_W-1:0]     bb_s2;
	// stage 3: sums
	logic                     v_s3;
	meta_t                    meta_s3;
	logic [SQ_W-1:0]          s_s3;
	logic [T_W-1:0]           t_s3;
	// stage 4 onward: index j is stage 4+j
	logic                     v_s4    [SQ_STAGES];
	meta_t                    meta_s4 [SQ_STAGES];
	logic                     hit_s4  [SQ_STAGES];
	sq_t                      sq_s4   [SQ_STAGES];

	logic                     v_in    [SQ_STAGES];
	meta_t                    meta_in [SQ_STAGES];
	logic                     hit_in  [SQ_STAGES];
	sq_t                      sq_in   [SQ_STAGES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			meta_s1 <= in_meta;
			dx_s1   <= offs(in_meta.kx, cfg.box_x, in_pair.x1, in_pair.x2);
			dy_s1   <= offs(in_meta.ky, cfg.box_y, in_pair.y1, in_pair.y2);
			dz_s1   <= offs(in_meta.kz, cfg.box_z, in_pair.z1, in_pair.z2);
			p_s1    <= ({1'b0, in_pair.d1} + {1'b0, in_pair.d2}) * cfg.scale;

			meta_s2 <= meta_s1;
			sqx_s2  <= mag(dx_s1) * mag(dx_s1);
			sqy_s2  <= mag(dy_s1) * mag(dy_s1);
			sqz_s2  <= mag(dz_s1) * mag(dz_s1);
			aa_s2   <= p_s1[P_W-1:COORD_W] * p_s1[P_W-1:COORD_W];
			ab_s2   <= p_s1[P_W-1:COORD_W] * p_s1[COORD_W-1:0];
			bb_s2   <= p_s1[COORD_W-1:0] * p_s1[COORD_W-1:0];

			meta_s3 <= meta_s2;
			s_s3    <= sqx_s2 + sqy_s2 + sqz_s2;
			t_s3    <= {aa_s2, {(2*COORD_W){1'b0}}}
			         + T_W'({ab_s2, {(COORD_W+1){1'b0}}})
			         + T_W'(bb_s2);
		end
	end

	// Integer squared distance to Q.24, times four, against the squared doubled contact scaled by the Q4.12 scale
	for (genvar j = 0; j < SQ_STAGES; j++) begin : g_sq
		if (j == 0) begin : g_first
			assign v_in[j]    = v_s3;
			assign meta_in[j] = meta_s3;
			assign hit_in[j]  = {{(T_W-SQ_W-26){1'b0}}, s_s3, 26'd0} < t_s3;
			assign sq_in[j]   = sq_step('{rad: s_s3, rem: '0, root: '0});
		end else begin : g_next
			assign v_in[j]    = v_s4[j-1];
			assign meta_in[j] = meta_s4[j-1];
			assign hit_in[j]  = hit_s4[j-1];
			assign sq_in[j]   = sq_step(sq_s4[j-1]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < SQ_STAGES; j++) v_s4[j] <= 1'b0;
		end else if (adv) begin
			for (int j = 0; j < SQ_STAGES; j++) v_s4[j] <= v_in[j];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int j = 0; j < SQ_STAGES; j++) begin
				meta_s4[j] <= meta_in[j];
				hit_s4[j]  <= hit_in[j];
				sq_s4[j]   <= sq_in[j];
			end
		end
	end

	assign out_valid = v_s4[SQ_STAGES-1];
	assign out_meta  = meta_s4[SQ_STAGES-1];
	assign out_hit   = hit_s4[SQ_STAGES-1];
	assign out_sep   = sq_s4[SQ_STAGES-1].root;

endmodule
